// ===== rtl/core/bftm_pkg.sv =====
// Shared types and constants for the byte FIFO with tail match.
package bftm_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int PATTERN_MAX_DEF = 8;
    localparam int CFG_W           = 7;
    localparam int PAT_W           = 64;
    localparam int PAT_BYTES       = PAT_W / 8;
    localparam int LEN_W           = 4;
    localparam int IN_W            = 2 + 8 + PAT_W + LEN_W;
    localparam int IN_TDATA_W      = ((IN_W + 7) / 8) * 8;
    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(64);

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_GET   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_TAIL  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    // shadow shift request: one byte pushed per successful put
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_tail_push;

endpackage

// ===== rtl/core/bftm_ram.sv =====
// Ring byte store: one write port, one read port, registered read data.
module bftm_ram #(
    parameter int DEPTH = bftm_pkg::DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    import bftm_pkg::*;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bftm_tail.sv =====
// Shadow of the newest put bytes and the tail pattern compare.
module bftm_tail #(
    parameter int PATTERN_MAX = bftm_pkg::PATTERN_MAX_DEF,
    parameter int CW          = 7
) (
    input  logic                        i_clk,
    input  bftm_pkg::t_tail_push        i_push,
    input  logic [bftm_pkg::PAT_W-1:0]  i_pattern,
    input  logic [bftm_pkg::LEN_W-1:0]  i_pattern_len,
    input  logic [CW-1:0]               i_count,
    output logic                        o_match
);
    import bftm_pkg::*;

    // r_shadow[0] is the newest byte
    logic [7:0]       r_shadow [PATTERN_MAX];
    logic [7:0]       pat_b    [PAT_BYTES];
    logic [LEN_W-1:0] len_sat;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_shadow[0] <= i_push.data;
            for (int i = 1; i < PATTERN_MAX; i++) begin
                r_shadow[i] <= r_shadow[i-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < PAT_BYTES; i++) begin
            pat_b[i] = i_pattern[8*i +: 8];
        end
    end

    assign len_sat = (32'(i_pattern_len) > 32'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                             : i_pattern_len;

    always_comb begin
        logic [LEN_W-1:0] idx;
        idx     = '0;
        o_match = (32'(i_count) >= 32'(len_sat));
        for (int j = 0; j < PATTERN_MAX; j++) begin
            idx = len_sat - LEN_W'(1) - LEN_W'(j);
            if ((LEN_W'(j) < len_sat) && (r_shadow[j] != pat_b[idx[2:0]])) begin
                o_match = 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/byte_fifo_with_tail_match.sv =====
// Top level: circular byte FIFO with tail pattern compare and stream ports.
// Results: put, clear and tail compare results reach the output register in the cycle after the
// input transaction; a get that finds data goes through the ring memory read register first.
// Throughput: one item per cycle for put, clear and compare while the output register is free or
// being taken and no capacity write is offered; a successful get holds off input during the read.
// Reset (i_rst_n low, synchronous): pointers and count cleared, capacity back to 64, no result held.
module byte_fifo_with_tail_match #(
    parameter int DEPTH       = bftm_pkg::DEPTH_DEF,
    parameter int PATTERN_MAX = bftm_pkg::PATTERN_MAX_DEF,
    localparam int CW         = $clog2(DEPTH + 1),
    localparam int OUT_W      = ((11 + CW + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata, LSB up: action[1:0], data_in[7:0], pattern[63:0], pattern_len[3:0], zero fill
    input  logic [bftm_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata, LSB up: status[1:0], data_out[7:0], fill_count[CW-1:0], tail_match, zero fill
    output logic [OUT_W-1:0]                  o_m_axis_tdata,
    // capacity write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bftm_pkg::CFG_W-1:0]        i_cfg_data
);
    import bftm_pkg::*;

    localparam int PW = $clog2(DEPTH);

    // ---------------------------------------------------------------- input unpack
    t_action            in_action;
    logic [7:0]         in_data;
    logic [PAT_W-1:0]   in_pattern;
    logic [LEN_W-1:0]   in_len;

    assign in_action  = t_action'(i_s_axis_tdata[1:0]);
    assign in_data    = i_s_axis_tdata[9:2];
    assign in_pattern = i_s_axis_tdata[10 +: PAT_W];
    assign in_len     = i_s_axis_tdata[10 + PAT_W +: LEN_W];

    // ---------------------------------------------------------------- state
    t_state             r_state, n_state;
    logic [PW-1:0]      r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]      r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]      r_count, n_count;
    logic [CFG_W-1:0]   r_capacity, n_capacity;
    logic [CW-1:0]      r_pend_fill;

    // output register
    logic               r_out_valid;
    t_status            r_out_status;
    logic [7:0]         r_out_data;
    logic [CW-1:0]      r_out_fill;
    logic               r_out_match;

    // ---------------------------------------------------------------- control
    logic               in_fire, cfg_fire, out_free;
    logic               get_read;      // get that finds data: goes through the ring memory
    logic               load_direct;   // result ready in the accept cycle
    logic               load_read;     // result from memory read data
    logic               in_ready, cfg_ready;

    logic [CW-1:0]      cap_eff;
    logic [CW-1:0]      wr_inc, rd_inc;
    logic [PW-1:0]      wr_adv, rd_adv;

    logic               mem_we, mem_re;
    logic [7:0]         mem_rdata;
    t_tail_push         tail_push;
    logic               tail_match;
    t_status            res_status;
    logic [CW-1:0]      res_fill;

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign in_fire  = i_s_axis_tvalid && in_ready;
    assign cfg_fire = i_cfg_valid && cfg_ready;
    assign get_read = in_fire && (in_action == ACT_GET) && (r_count != '0);

    // capacity of zero acts as one, anything beyond the ring acts as the full ring
    always_comb begin
        if (r_capacity == '0) begin
            cap_eff = CW'(1);
        end else if (32'(r_capacity) > 32'(DEPTH)) begin
            cap_eff = CW'(DEPTH);
        end else begin
            cap_eff = CW'(r_capacity);
        end
    end

    // pointer advance with wrap at the capacity
    assign wr_inc = CW'(r_wr_ptr) + CW'(1);
    assign rd_inc = CW'(r_rd_ptr) + CW'(1);
    assign wr_adv = (wr_inc >= cap_eff) ? '0 : wr_inc[PW-1:0];
    assign rd_adv = (rd_inc >= cap_eff) ? '0 : rd_inc[PW-1:0];

    // FSM next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (get_read) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // FSM outputs; a capacity write wins over an item offered in the same cycle
    always_comb begin
        in_ready    = 1'b0;
        cfg_ready   = 1'b0;
        load_direct = 1'b0;
        load_read   = 1'b0;
        case (r_state)
            S_IDLE: begin
                in_ready    = out_free && !i_cfg_valid;
                cfg_ready   = 1'b1;
                load_direct = in_fire && !get_read;
            end
            S_READ: begin
                load_read = out_free;
            end
            default: ;
        endcase
    end

    assign o_s_axis_tready = in_ready;
    assign o_cfg_ready     = cfg_ready;

    // pointer, count and capacity update
    always_comb begin
        n_rd_ptr   = r_rd_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_count    = r_count;
        n_capacity = r_capacity;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        tail_push  = '{valid: 1'b0, data: in_data};
        res_status = ST_OK;
        if (cfg_fire) begin
            // capacity write also empties the ring
            n_capacity = i_cfg_data;
            n_rd_ptr   = '0;
            n_wr_ptr   = '0;
            n_count    = '0;
        end else if (in_fire) begin
            case (in_action)
                ACT_PUT: begin
                    if (r_count >= cap_eff) begin
                        res_status = ST_FULL;
                    end else begin
                        mem_we          = 1'b1;
                        tail_push.valid = 1'b1;
                        n_wr_ptr        = wr_adv;
                        n_count         = r_count + CW'(1);
                    end
                end
                ACT_GET: begin
                    if (r_count == '0) begin
                        res_status = ST_EMPTY;
                    end else begin
                        mem_re   = 1'b1;
                        n_rd_ptr = rd_adv;
                        n_count  = r_count - CW'(1);
                    end
                end
                ACT_CLEAR: begin
                    n_rd_ptr = '0;
                    n_wr_ptr = '0;
                    n_count  = '0;
                end
                ACT_TAIL: ;
                default: ;
            endcase
        end
        res_fill = n_count;
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_ptr   <= n_rd_ptr;
            r_wr_ptr   <= n_wr_ptr;
            r_count    <= n_count;
            r_capacity <= n_capacity;
            if (load_direct || load_read) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (get_read) begin
            r_pend_fill <= res_fill;
        end
        if (load_direct) begin
            r_out_status <= res_status;
            r_out_data   <= '0;
            r_out_fill   <= res_fill;
            r_out_match  <= (in_action == ACT_TAIL) ? tail_match : 1'b0;
        end else if (load_read) begin
            r_out_status <= ST_OK;
            r_out_data   <= mem_rdata;
            r_out_fill   <= r_pend_fill;
            r_out_match  <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_match, r_out_fill, r_out_data, 2'(r_out_status)});

    // ---------------------------------------------------------------- submodules
    bftm_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (in_data),
        .i_re    (mem_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (mem_rdata)
    );

    bftm_tail #(
        .PATTERN_MAX (PATTERN_MAX),
        .CW          (CW)
    ) u_tail (
        .i_clk         (i_clk),
        .i_push        (tail_push),
        .i_pattern     (in_pattern),
        .i_pattern_len (in_len),
        .i_count       (r_count),
        .o_match       (tail_match)
    );

    // ---------------------------------------------------------------- assertions
    // count never exceeds the usable slots (capacity changes only with an empty ring)
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cap_eff)
        else $error("fill count above capacity");

    // write pointer stays inside the usable ring
    a_wr_ptr_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_wr_ptr) < cap_eff)
        else $error("write pointer outside ring");

    // a memory read always finds the output register free
    a_read_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("output register busy during read");

    // the read result lands in the next cycle and the block returns to idle
    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("read result not delivered");

endmodule

// ===== sim/byte_fifo_with_tail_match_tb.sv =====
// Self-checking testbench for the byte FIFO with tail match: random stream traffic, shadow ring.
module byte_fifo_with_tail_match_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bftm_pkg::*;

    localparam int RING_DEPTH = DEPTH_DEF;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int RES_W      = ((11 + CNT_W + 7) / 8) * 8;
    localparam int LONG_HOLD  = 300;   // cycles the result side refuses during the fill test
    localparam int SETTLE     = 6;     // waiting time after the last result, leave some margin

    // Result fields, lowest bit up: status, data_out, fill_count, tail_match.
    typedef struct packed {
        logic             match;
        logic [CNT_W-1:0] fill;
        logic [7:0]       data_out;
        t_status          status;
    } t_result;

    // Shadow of the ring: updated on every accepted input transaction, so the
    // stimulus can also ask it which bytes are newest when building patterns.
    class t_ring_shadow;
        logic [7:0]  ring [RING_DEPTH];
        int unsigned rd_ptr, wr_ptr, held, slots;
        t_result     pending[$];
        int unsigned errors;

        function new();
            foreach (ring[i]) ring[i] = 8'h00;
            slots  = RING_DEPTH;
            errors = 0;
            empty_ring();
        endfunction

        function void empty_ring();
            rd_ptr = 0;
            wr_ptr = 0;
            held   = 0;
        endfunction

        // a capacity write also empties the ring; zero acts as one, oversize as full depth
        function void set_capacity(logic [CFG_W-1:0] value);
            if (value == 0) slots = 1;
            else if (value > RING_DEPTH) slots = RING_DEPTH;
            else slots = value;
            empty_ring();
        endfunction

        function int unsigned step_ptr(int unsigned p);
            return (p + 1 >= slots) ? 0 : p + 1;
        endfunction

        // newest n bytes in text order: byte n-1 is the most recent put
        function logic [PAT_W-1:0] newest_bytes(int unsigned n);
            logic [PAT_W-1:0] p;
            int unsigned      pos;
            p   = '0;
            pos = wr_ptr;
            for (int unsigned k = 0; k < n; k++) begin
                pos = (pos == 0) ? slots - 1 : pos - 1;
                p[8 * (n - 1 - k) +: 8] = ring[pos];
            end
            return p;
        endfunction

        function void note_action(t_action act, logic [7:0] data, logic [PAT_W-1:0] pat,
                                  logic [LEN_W-1:0] plen);
            t_result     r;
            int unsigned n;
            r = '{match: 1'b0, fill: '0, data_out: 8'h00, status: ST_OK};
            case (act)
                ACT_PUT: begin
                    if (held >= slots) begin
                        r.status = ST_FULL;
                    end else begin
                        ring[wr_ptr] = data;
                        wr_ptr = step_ptr(wr_ptr);
                        held++;
                    end
                end
                ACT_GET: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.data_out = ring[rd_ptr];
                        rd_ptr = step_ptr(rd_ptr);
                        held--;
                    end
                end
                ACT_CLEAR: empty_ring();
                default: begin
                    // length saturates at the pattern size; zero length always matches
                    n = (plen > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : plen;
                    if (held >= n)
                        r.match = (newest_bytes(n) & ((64'd1 << (8 * n)) - 1)) ==
                                  (pat & ((64'd1 << (8 * n)) - 1)) || n == PAT_BYTES &&
                                  newest_bytes(n) == pat;
                end
            endcase
            r.fill = CNT_W'(held);
            pending.push_back(r);
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result transaction with nothing outstanding, got %h",
                         $time, got);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                errors++;
                report("status", want.status, got.status);
            end
            if (got.data_out !== want.data_out) begin
                errors++;
                report("data_out", want.data_out, got.data_out);
            end
            if (got.fill !== want.fill) begin
                errors++;
                report("fill_count", want.fill, got.fill);
            end
            if (got.match !== want.match) begin
                errors++;
                report("tail_match", want.match, got.match);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_TDATA_W-1:0] i_s_axis_tdata = '0;    // action, data_in, pattern, pattern_len, fill
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [RES_W-1:0]      o_m_axis_tdata;         // status, data_out, fill_count, tail_match
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    t_ring_shadow sb = new();

    // idling knobs, changed per phase by the stimulus
    int unsigned gap_pct   = 15;
    int unsigned stall_pct = 15;
    // long holds asked for so far; only the stimulus writes it
    int unsigned hold_requests = 0;

    byte_fifo_with_tail_match dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Hard limit: far beyond the slowest legal run (about 800 transactions with
    // worst-case stalls, the long hold and the capacity writes).
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Result side. Values are sampled straight after the edge, i.e. before any
    // nonblocking update of that edge lands, so checks see what the DUT saw.
    initial begin
        int unsigned hold_left, burst_left, hold_seen;
        hold_left  = 0;
        burst_left = 0;
        hold_seen  = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata[$bits(t_result)-1:0]);
            if (hold_requests != hold_seen) begin
                // long refusal, counted here so the sender keeps offering meanwhile
                hold_left = LONG_HOLD;
                hold_seen = hold_requests;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                i_m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                burst_left = $urandom_range(1, 6) - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // One input transaction. Entered just after a rising edge; tvalid stays high
    // into the next item unless an idle burst is drawn.
    task automatic send_item(t_action act, logic [7:0] data, logic [PAT_W-1:0] pat,
                             logic [LEN_W-1:0] plen);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_TDATA_W - IN_W){1'b0}}, plen, pat, data, act};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_action(act, data, pat, plen);
        if ($urandom_range(0, 99) < gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every outstanding result is back
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // capacity writes only with the block idle
    task automatic write_capacity(logic [CFG_W-1:0] value);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_capacity(value);
    endtask

    // Random traffic. Most tail compares carry the real newest bytes so that
    // matches happen; some of those get one bit flipped to miss narrowly.
    task automatic random_items(int count, int put_pct, int get_pct);
        t_action          act;
        logic [7:0]       data;
        logic [PAT_W-1:0] pat, tail;
        logic [LEN_W-1:0] plen;
        int unsigned      r, n;
        for (int i = 0; i < count; i++) begin
            r    = $urandom_range(0, 99);
            data = ($urandom_range(0, 1) == 0) ? 8'h30 + 8'($urandom_range(0, 2))
                                               : 8'($urandom);
            pat  = {$urandom, $urandom};
            plen = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(9, 15))
                                               : LEN_W'($urandom_range(0, 8));
            if (r < put_pct) act = ACT_PUT;
            else if (r < put_pct + get_pct) act = ACT_GET;
            else if (r < put_pct + get_pct + 4) act = ACT_CLEAR;
            else act = ACT_TAIL;
            if (act == ACT_TAIL) begin
                n = (plen > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : plen;
                if (n > 0 && sb.held >= n && $urandom_range(0, 99) < 65) begin
                    tail = sb.newest_bytes(n);
                    for (int b = 0; b < n; b++) pat[8 * b +: 8] = tail[8 * b +: 8];
                    if ($urandom_range(0, 4) == 0) pat[$urandom_range(0, 8 * n - 1)] ^= 1'b1;
                end
            end
            send_item(act, data, pat, plen);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset capacity 64
        send_item(ACT_TAIL, 8'h00, '1, 4'd0);                   // zero length matches on empty
        send_item(ACT_GET, 8'h00, '0, 4'd0);                    // empty
        send_item(ACT_PUT, 8'h00, '0, 4'd0);
        send_item(ACT_PUT, 8'hFF, '0, 4'd0);
        send_item(ACT_PUT, 8'hA5, '0, 4'd0);
        send_item(ACT_TAIL, 8'h00, 64'hFFFF_FFFF_FFA5_FF00, 4'd3); // hit, upper bytes ignored
        send_item(ACT_TAIL, 8'h00, 64'h0000_0000_0000_FFA5, 4'd3); // reversed order misses
        send_item(ACT_TAIL, 8'h00, 64'h0000_0000_A5FF_0000, 4'd4); // fewer bytes held than len
        send_item(ACT_TAIL, 8'h00, '0, 4'd15);                    // saturates to eight
        send_item(ACT_GET, 8'h00, '0, 4'd0);
        send_item(ACT_TAIL, 8'h00, 64'h0000_0000_0000_A5FF, 4'd2);
        send_item(ACT_CLEAR, 8'h00, '0, 4'd0);
        send_item(ACT_GET, 8'h00, '0, 4'd0);

        // single slot: full on second put
        write_capacity(7'd1);
        send_item(ACT_PUT, 8'h5A, '0, 4'd0);
        send_item(ACT_PUT, 8'hC3, '0, 4'd0);
        send_item(ACT_TAIL, 8'h00, 64'h0000_0000_0000_005A, 4'd1);
        send_item(ACT_GET, 8'h00, '0, 4'd0);
        send_item(ACT_GET, 8'h00, '0, 4'd0);

        // capacity zero behaves as one slot
        write_capacity(7'd0);
        send_item(ACT_PUT, 8'h81, '0, 4'd0);
        send_item(ACT_PUT, 8'h7E, '0, 4'd0);
        send_item(ACT_TAIL, 8'h00, 64'h0000_0000_0000_0081, 4'd9);

        // three slots: tail compare across the pointer wrap
        write_capacity(7'd3);
        send_item(ACT_PUT, 8'h11, '0, 4'd0);
        send_item(ACT_PUT, 8'h22, '0, 4'd0);
        send_item(ACT_GET, 8'h00, '0, 4'd0);
        send_item(ACT_PUT, 8'h33, '0, 4'd0);
        send_item(ACT_PUT, 8'h44, '0, 4'd0);
        send_item(ACT_TAIL, 8'h00, 64'h0000_0000_0022_3344, 4'd3);

        // random phases over several capacities
        write_capacity(7'd2);
        random_items(60, 45, 40);
        write_capacity(7'd0);
        random_items(50, 50, 40);

        // fill test: results held off while puts keep coming, ring and input stall
        write_capacity(7'd127);
        gap_pct = 0;
        hold_requests++;
        random_items(100, 92, 2);
        gap_pct = 15;

        // sender pause with no register write, then empty it out again
        drain();
        random_items(80, 30, 60);

        write_capacity(7'd5);
        stall_pct = 0;                      // stretch with a ready result side
        random_items(70, 50, 35);
        stall_pct = 25;
        write_capacity(7'd1);
        random_items(40, 50, 40);
        write_capacity(7'd64);
        gap_pct = 30;
        random_items(70, 55, 35);
        write_capacity(7'd100);
        random_items(60, 55, 30);
        gap_pct = 10;
        write_capacity(7'd3);
        random_items(60, 45, 40);
        write_capacity(7'd17);
        random_items(70, 55, 35);

        // closing part without any idling
        write_capacity(7'd8);
        gap_pct   = 0;
        stall_pct = 0;
        random_items(80, 50, 35);

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
